// ----- hdl/lsv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsv_pkg
// shared constants, types and tables for the line sensor vote/angle unit
// ----------------------------------------------------------------------------
package lsv_pkg;

  localparam int SensorCount = 8;
  localparam int WindowLen   = 5;
  localparam int WinIdxW     = $clog2(WindowLen);
  localparam int WinFillW    = $clog2(WindowLen + 1);
  localparam int AngleW      = 12;
  localparam int CordicIters = 20;
  localparam int IterW       = 5;
  localparam int CordicW     = 36;
  localparam int ZW          = 23;
  localparam logic [10:0] AngleMax = 11'd1791;
  localparam logic [7:0]  SpfReset = 8'd10;
  localparam logic [0:0]  RegSpf   = 1'b0;

  typedef struct packed {
    logic start;
  } lsv_cmd_t;

  typedef struct packed {
    logic done;
  } lsv_sts_t;

  function automatic logic signed [7:0] sensor_pos(input logic [2:0] idx);
    logic signed [7:0] p;
    case (idx)
      3'd0: p = -8'sd42;
      3'd1: p = -8'sd30;
      3'd2: p = -8'sd18;
      3'd3: p = -8'sd6;
      3'd4: p = 8'sd6;
      3'd5: p = 8'sd18;
      3'd6: p = 8'sd30;
      default: p = 8'sd42;
    endcase
    return p;
  endfunction

  function automatic logic [ZW-1:0] atan_q8(input logic [IterW-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:  v = 23'd1152000;
      5'd1:  v = 23'd680065;
      5'd2:  v = 23'd359328;
      5'd3:  v = 23'd182400;
      5'd4:  v = 23'd91554;
      5'd5:  v = 23'd45822;
      5'd6:  v = 23'd22916;
      5'd7:  v = 23'd11459;
      5'd8:  v = 23'd5730;
      5'd9:  v = 23'd2865;
      5'd10: v = 23'd1432;
      5'd11: v = 23'd716;
      5'd12: v = 23'd358;
      5'd13: v = 23'd179;
      5'd14: v = 23'd90;
      5'd15: v = 23'd45;
      5'd16: v = 23'd22;
      5'd17: v = 23'd11;
      5'd18: v = 23'd6;
      5'd19: v = 23'd3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/lsv_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsv_sample_if / lsv_result_if
// valid/ready channels for samples and results
// ----------------------------------------------------------------------------
interface lsv_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] sensor_bits;
  modport source (output valid, output sensor_bits, input ready);
  modport sink (input valid, input sensor_bits, output ready);
endinterface

interface lsv_result_if;
  logic              valid;
  logic              ready;
  logic signed [11:0] angle_centideg;
  logic              line_found;
  logic              window_full;
  modport source (output valid, output angle_centideg, output line_found,
                  output window_full, input ready);
  modport sink (input valid, input angle_centideg, input line_found,
                input window_full, output ready);
endinterface

// ----- hdl/lsv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsv_ctrl
// frame sequencer: accepts samples, starts angle datapath at frame end
// ----------------------------------------------------------------------------
module lsv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              frame_end_i,
  output logic              accept_o,
  output lsv_pkg::lsv_cmd_t cmd_o,
  input  lsv_pkg::lsv_sts_t sts_i,
  output logic              out_valid_o,
  input  logic              out_ready_i
);
  import lsv_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StBusy = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign accept_o    = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign cmd_o.start = accept_o && frame_end_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (cmd_o.start) state_d = StBusy;
      StBusy: if (sts_i.done) state_d = StOut;
      StOut:  if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.done |-> state_q == StBusy) else $error("done outside busy");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == StBusy) else $error("start lost");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
endmodule

// ----- hdl/lsv_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsv_datapath
// vote counters, centroid, iterative cordic and median window
// ----------------------------------------------------------------------------
module lsv_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        spf_i,
  input  logic              accept_i,
  input  logic [7:0]        sensor_bits_i,
  output logic              frame_end_o,
  input  lsv_pkg::lsv_cmd_t cmd_i,
  output lsv_pkg::lsv_sts_t sts_o,
  output logic signed [11:0] angle_o,
  output logic              line_found_o,
  output logic              window_full_o
);
  import lsv_pkg::*;

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhCordic = 2'd1;
  localparam logic [1:0] PhMedian = 2'd2;
  localparam logic [1:0] PhStore  = 2'd3;

  logic [7:0] votes_q [SensorCount];
  logic [7:0] cnt_q;
  logic [7:0] frame_len;
  logic [7:0] half;
  logic [3:0] n_c;
  logic signed [8:0] sum_c;

  logic [1:0] ph_q;
  logic [IterW-1:0] it_q;
  logic signed [CordicW-1:0] x_q, y_q;
  logic signed [ZW+1:0] z_q;
  logic neg_q, found_q;
  logic signed [AngleW-1:0] last_q;
  logic signed [AngleW-1:0] win_q [WindowLen];
  logic [WinIdxW-1:0] widx_q;
  logic [WinFillW-1:0] wfill_q;
  logic signed [AngleW-1:0] res_q;
  logic full_q;

  assign frame_len   = (spf_i == 8'd0) ? 8'd1 : spf_i;
  assign half        = frame_len >> 1;
  assign frame_end_o = (cnt_q + 8'd1) >= frame_len;

  // confirmation with the vote of the current sample included
  always_comb begin
    logic [7:0] v;
    n_c   = '0;
    sum_c = '0;
    for (int i = 0; i < SensorCount; i++) begin
      v = votes_q[i];
      if (!sensor_bits_i[i] && v != 8'hff) v = v + 8'd1;
      if (v > half) begin
        n_c   = n_c + 4'd1;
        sum_c = sum_c + 9'(sensor_pos(3'(i)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < SensorCount; i++) votes_q[i] <= '0;
    end else if (accept_i) begin
      if (frame_end_o) begin
        cnt_q <= '0;
        for (int i = 0; i < SensorCount; i++) votes_q[i] <= '0;
      end else begin
        cnt_q <= cnt_q + 8'd1;
        for (int i = 0; i < SensorCount; i++)
          if (!sensor_bits_i[i] && votes_q[i] != 8'hff) votes_q[i] <= votes_q[i] + 8'd1;
      end
    end
  end

  logic signed [CordicW-1:0] dx, dy;
  logic [ZW-1:0] atan_c;
  logic [ZW+1:0] zr;
  logic [10:0] mag;
  logic signed [AngleW-1:0] new_ang;
  assign dx     = y_q >>> it_q;
  assign dy     = x_q >>> it_q;
  assign atan_c = atan_q8(it_q);
  always_comb begin
    zr  = z_q[ZW+1] ? '0 : ($unsigned(z_q) + 25'd128);
    mag = (zr[ZW+1:8] > 17'(AngleMax)) ? AngleMax : zr[18:8];
    new_ang = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // median of five: rank count, one comparison set per entry
  logic signed [AngleW-1:0] med_c;
  always_comb begin
    int le;
    med_c = win_q[0];
    for (int i = 0; i < WindowLen; i++) begin
      le = 0;
      for (int j = 0; j < WindowLen; j++) begin
        if (win_q[j] < win_q[i] || (win_q[j] == win_q[i] && j <= i)) le++;
      end
      if (le - 1 == WindowLen / 2) med_c = win_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == PhStore) begin
      win_q[widx_q] <= new_ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; it_q <= '0; last_q <= '0; widx_q <= '0; wfill_q <= '0;
      found_q <= 1'b0; neg_q <= 1'b0; full_q <= 1'b0; res_q <= '0;
      x_q <= '0; y_q <= '0; z_q <= '0;
    end else begin
      case (ph_q)
        PhIdle: if (cmd_i.start) begin
          found_q <= (n_c != 4'd0);
          neg_q   <= sum_c[8];
          x_q     <= CordicW'(n_c * 11'd130) <<< 20;
          y_q     <= CordicW'(sum_c[8] ? -sum_c : sum_c) <<< 20;
          z_q     <= '0;
          it_q    <= '0;
          ph_q    <= (n_c != 4'd0) ? PhCordic : PhMedian;
        end
        PhCordic: begin
          if (!y_q[CordicW-1]) begin
            x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + $signed({2'b0, atan_c});
          end else begin
            x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - $signed({2'b0, atan_c});
          end
          it_q <= it_q + 1'b1;
          if (it_q == IterW'(CordicIters - 1)) begin
            ph_q <= PhStore;
          end
        end
        PhStore:  ph_q <= PhMedian;
        PhMedian: ph_q <= PhIdle;
        default: ph_q <= PhIdle;
      endcase
      // accumulator is final here, push the new angle into the window
      if (ph_q == PhStore) begin
        last_q <= new_ang;
        res_q  <= new_ang;
        widx_q <= (widx_q == WinIdxW'(WindowLen - 1)) ? '0 : widx_q + 1'b1;
        if (wfill_q != WinFillW'(WindowLen)) wfill_q <= wfill_q + 1'b1;
      end
      if (ph_q == PhMedian) begin
        full_q <= (wfill_q == WinFillW'(WindowLen));
        if (wfill_q == WinFillW'(WindowLen)) res_q <= med_c;
        else if (!found_q) res_q <= last_q;
      end
    end
  end

  assign sts_o.done    = (ph_q == PhMedian);
  assign angle_o       = res_q;
  assign line_found_o  = found_q;
  assign window_full_o = full_q;

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wfill_q <= WinFillW'(WindowLen)) else $error("fill overflow");
  a_idx_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    widx_q < WinIdxW'(WindowLen)) else $error("index out of range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> ph_q == PhIdle) else $error("start while busy");
endmodule

// ----- hdl/line_sensor_vote_angle_median_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_vote_angle_median_unit
// frame voting of line sensor samples, centroid arctangent, median of five
// ----------------------------------------------------------------------------
// A sample is taken while no frame result is being computed.
// On the last sample of a frame the iterative cordic unit runs its
// micro-rotations (one micro-rotation per cycle), a store step writes the
// angle into the window, then a median step picks the window median, and the
// result is held until taken; new samples wait during that time.
// A frame with no confirmed sensor skips the cordic and store steps and goes
// straight to the median step, then the result is held until taken.
module line_sensor_vote_angle_median_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsv_sample_if.sink  in_if,
  lsv_result_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lsv_pkg::*;

  logic [7:0] spf_q;
  logic accept, frame_end;
  lsv_cmd_t cmd;
  lsv_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'(RegSpf * 4)) ? {24'd0, spf_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) spf_q <= SpfReset;
    else if (psel && penable && pwrite && paddr == 2'(RegSpf * 4)) spf_q <= pwdata[7:0];
  end

  lsv_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .frame_end_i(frame_end), .accept_o(accept),
    .cmd_o(cmd), .sts_i(sts),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready)
  );

  lsv_datapath u_dp (
    .clk_i, .rst_ni,
    .spf_i(spf_q), .accept_i(accept), .sensor_bits_i(in_if.sensor_bits),
    .frame_end_o(frame_end), .cmd_i(cmd), .sts_o(sts),
    .angle_o(out_if.angle_centideg), .line_found_o(out_if.line_found),
    .window_full_o(out_if.window_full)
  );
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives sensor samples and register writes into the vote/angle/median unit,
// predicts every frame heading independently and compares each result item
// ----------------------------------------------------------------------------
module testbench;
  import lsv_pkg::*;

  localparam int MaxGap      = 12;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 600000;
  localparam logic [1:0] SpfAddr = 2'(RegSpf * 4);

  typedef struct {
    logic signed [11:0] angle;
    bit                 found;
    bit                 full;
  } heading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;

  lsv_sample_if sample_ch ();
  lsv_result_if result_ch ();

  line_sensor_vote_angle_median_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (sample_ch.sink),
    .out_if  (result_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [7:0]         frame_len;
  logic [7:0]         votes [SensorCount];
  int                 taken;
  logic signed [11:0] held_angle;
  logic signed [11:0] ring [WindowLen];
  int                 ring_pos;
  int                 ring_fill;
  heading_t           pending_headings [$];

  longint arctan_step [CordicIters] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};
  int offsets_mm [SensorCount] = '{-42, -30, -18, -6, 6, 18, 30, 42};

  int  errors, shown;
  int  samples_sent, frames_seen, lost_frames, full_frames;
  int  cycles;
  int  hold_cycles;
  bit  calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("line_sensor_vote_angle_median_unit: mismatch");
      $finish;
    end
  end

  function automatic logic signed [11:0] centroid_angle(int sum, int n);
    longint x, y, z, dx, dy, r;
    x = 64'(130 * n) <<< 20;
    y = 64'(sum < 0 ? -sum : sum) <<< 20;
    z = 0;
    for (int i = 0; i < CordicIters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step[i];
      end else begin
        x -= dx; y += dy; z -= arctan_step[i];
      end
    end
    if (z < 0) z = 0;
    r = (z + 128) >>> 8;
    if (r > 1791) r = 1791;
    return sum < 0 ? 12'(-r) : 12'(r);
  endfunction

  function automatic logic signed [11:0] ring_median();
    logic signed [11:0] t [WindowLen];
    logic signed [11:0] s;
    t = ring;
    for (int i = 0; i < WindowLen - 1; i++)
      for (int j = 0; j < WindowLen - 1 - i; j++)
        if (t[j] > t[j + 1]) begin
          s = t[j]; t[j] = t[j + 1]; t[j + 1] = s;
        end
    return t[WindowLen / 2];
  endfunction

  // called once per accepted sample
  task automatic vote_sample(input logic [7:0] bits);
    int       frame, n, sum;
    heading_t h;
    frame = (frame_len == 0) ? 1 : frame_len;
    for (int i = 0; i < SensorCount; i++)
      if (!bits[i] && votes[i] != 8'hff) votes[i]++;
    taken++;
    if (taken < frame) return;
    n = 0;
    sum = 0;
    for (int i = 0; i < SensorCount; i++)
      if (votes[i] > frame / 2) begin
        n++;
        sum += offsets_mm[i];
      end
    foreach (votes[i]) votes[i] = '0;
    taken = 0;
    if (n > 0) begin
      h.angle = centroid_angle(sum, n);
      held_angle = h.angle;
      ring[ring_pos] = h.angle;
      ring_pos = (ring_pos + 1) % WindowLen;
      if (ring_fill < WindowLen) ring_fill++;
    end else begin
      h.angle = held_angle;
    end
    h.full = ring_fill >= WindowLen;
    if (h.full) h.angle = ring_median();
    h.found = n > 0;
    pending_headings.push_back(h);
  endtask

  // result checking
  always @(posedge clk_i) begin
    heading_t want;
    if (result_ch.valid && result_ch.ready) begin
      frames_seen++;
      if (!result_ch.line_found) lost_frames++;
      if (result_ch.window_full) full_frames++;
      if (pending_headings.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result item angle %0d", result_ch.angle_centideg);
        end
      end else begin
        want = pending_headings.pop_front();
        if (result_ch.angle_centideg !== want.angle || result_ch.line_found !== want.found
            || result_ch.window_full !== want.full) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("frame %0d: expected angle %0d found %0b full %0b, got %0d %0b %0b",
                     frames_seen, want.angle, want.found, want.full,
                     result_ch.angle_centideg, result_ch.line_found,
                     result_ch.window_full);
          end
        end
      end
    end
  end

  // result receiver with random stalls and an optional long hold-off
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      int stall;
      if (hold_cycles > 0) begin
        result_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      stall = calm ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk_i); while (!(result_ch.valid && result_ch.ready));
      @(negedge clk_i);
    end
  end

  task automatic send_sample(input logic [7:0] bits);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_ch.sensor_bits = bits;
    sample_ch.valid = 1'b1;
    do @(posedge clk_i); while (!(sample_ch.valid && sample_ch.ready));
    vote_sample(bits);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // entered at a falling edge right after the last sample was taken
  task automatic drain();
    sample_ch.valid = 1'b0;
    while (pending_headings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // only called with the unit idle
  task automatic set_frame_len(input logic [7:0] v);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = SpfAddr; pwdata = 32'(v); penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    frame_len = v;
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata[7:0] !== v) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("register readback: expected %0d, got %0d", v, prdata[7:0]);
      end
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  // a line under one to three adjacent sensors, sometimes noisy, lost or random
  function automatic logic [7:0] line_pattern();
    logic [7:0] mask;
    int c, w, pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 8'hff;
    if (pick == 1) return 8'($urandom);
    c = $urandom_range(0, SensorCount - 1);
    w = $urandom_range(1, 3);
    mask = '0;
    for (int i = 0; i < w; i++)
      if (c + i < SensorCount) mask[c + i] = 1'b1;
    if (pick < 6) mask ^= 8'(1 << $urandom_range(0, 7));
    return ~mask;
  endfunction

  task automatic test_reset_frame();
    // default ten-sample frame, line straight then off to one side
    for (int i = 0; i < 10; i++) send_sample(8'he7);
    for (int i = 0; i < 10; i++) send_sample(i < 6 ? 8'hfe : 8'hff);
    drain();
  endtask

  task automatic test_single_sample_frames();
    logic [7:0] edges [12] = '{8'h00, 8'hff, 8'hfe, 8'h7f, 8'hfd, 8'hbf, 8'hfb, 8'hdf,
                               8'hf7, 8'hef, 8'h3c, 8'h0f};
    set_frame_len(8'd0);
    foreach (edges[i]) send_sample(edges[i]);
    drain();
    set_frame_len(8'd1);
    send_sample(8'hff);
    send_sample(8'hf0);
    drain();
  endtask

  task automatic test_len_lowered_mid_frame();
    set_frame_len(8'd9);
    for (int i = 0; i < 6; i++) send_sample(8'hcf);
    drain();
    set_frame_len(8'd3);
    send_sample(8'hcf);
    send_sample(8'hfc);
    drain();
  endtask

  task automatic test_longest_frame();
    set_frame_len(8'd255);
    for (int i = 0; i < 255; i++) send_sample(i < 128 ? 8'h00 : 8'h7e);
    drain();
  endtask

  task automatic test_output_backpressure();
    set_frame_len(8'd1);
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_sample(line_pattern());
    drain();
  endtask

  task automatic test_random_frames();
    logic [7:0] len;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: len = 8'($urandom_range(0, 3));
        1: len = 8'($urandom_range(4, 12));
        2: len = 8'($urandom_range(1, 6));
        default: len = 8'($urandom_range(0, 20));
      endcase
      set_frame_len(len);
      calm = (phase == 5);
      for (int i = 0; i < 80; i++) send_sample(line_pattern());
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sensor_bits = '0;
    calm = 1'b0;
    hold_cycles = 0;
    cycles = 0;
    errors = 0; shown = 0;
    samples_sent = 0; frames_seen = 0; lost_frames = 0; full_frames = 0;
    frame_len = SpfReset;
    foreach (votes[i]) votes[i] = '0;
    foreach (ring[i]) ring[i] = '0;
    taken = 0; held_angle = '0; ring_pos = 0; ring_fill = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_frame();
    test_single_sample_frames();
    test_len_lowered_mid_frame();
    test_longest_frame();
    test_output_backpressure();
    test_random_frames();

    $display("covered %0d samples, %0d frames (%0d without line, %0d median of full window)",
             samples_sent, frames_seen, lost_frames, full_frames);
    $display("frame lengths 0..255, long output hold-off, %0d errors", errors);
    if (errors == 0 && pending_headings.size() == 0) begin
      $display("line_sensor_vote_angle_median_unit: match");
    end else begin
      $display("line_sensor_vote_angle_median_unit: mismatch");
    end
    $finish;
  end

endmodule
